// ===== rtl/gwps_pkg.sv =====
// Shared field widths and codes for the grid word path search unit.
package gwps_pkg;

  // Field widths of the request and configuration ports and of the direction code.
  localparam int MODE_W = 2;
  localparam int SLOT_W = 8;
  localparam int CHAR_W = 8;
  localparam int LEN_W  = 6;
  localparam int CFG_W  = 5;
  localparam int DIR_W  = 3;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_LOAD_GRID = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_WORD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH    = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  // Neighbor directions, tried in this order; DIR_DONE means all were tried.
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd2;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

endpackage

// ===== rtl/grid_word_path_search_unit.sv =====
// Grid word path search unit: character grid, word store and backtracking search sequencer.
//
// A request is taken when start is high and busy is low. A grid or word load is
// written in the cycle it is taken and leaves busy low, so loads can follow each
// other back to back. A search with a zero grid dimension or an empty word answers
// in the next cycle and also leaves busy low. Any other search request raises busy
// and walks the grid depth first with one shared neighbor address adder under a
// small sequencer; the single result appears on path_found_o with done_o high for
// exactly one cycle and cannot be held off. Search time depends on the data: each
// start cell passes the read, compare and advance states, a neighbor outside the
// grid is skipped in the loop state, one inside also takes the check state, a step
// back takes the reload state, and after a hit the visited map is cleared along the
// found path (busy stays high then). The grid, visited, word and path memories each
// have one registered read port, so a neighbor is checked in the state after its
// address is set. After reset the unit clears its visited map, MAX_ROWS*MAX_COLS
// cells (256 at the defaults) with busy high; configuration writes are still taken.
module grid_word_path_search_unit #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16,
  parameter int MAX_WORD = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request channel.
  input  logic                         start,
  output logic                         busy,
  input  logic [gwps_pkg::MODE_W-1:0]  mode_i,
  input  logic [gwps_pkg::SLOT_W-1:0]  slot_index_i,
  input  logic [gwps_pkg::CHAR_W-1:0]  char_value_i,
  input  logic [gwps_pkg::LEN_W-1:0]   word_length_i,
  // Result channel.
  output logic                         done_o,
  output logic                         path_found_o,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [gwps_pkg::CFG_W-1:0]   cfg_wdata_i
);

  localparam int GRID = MAX_ROWS * MAX_COLS;
  localparam int GW   = (GRID > 1) ? $clog2(GRID) : 1;
  localparam int RW   = $clog2(MAX_ROWS + 1);
  localparam int CW   = $clog2(MAX_COLS + 1);
  localparam int DW   = $clog2(MAX_WORD + 1);
  localparam int WW   = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

  // Sequencer state codes.
  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_CMP    = 4'd3;
  localparam logic [3:0] S_NEXT   = 4'd4;
  localparam logic [3:0] S_LOOP   = 4'd5;
  localparam logic [3:0] S_CHK    = 4'd6;
  localparam logic [3:0] S_POPW   = 4'd7;
  localparam logic [3:0] S_CLEAN  = 4'd8;
  localparam logic [3:0] S_CLEANW = 4'd9;

  // One path position: cell index, its row and column, and the next direction.
  typedef struct packed {
    logic [GW-1:0]              pos;
    logic [RW-1:0]              row;
    logic [CW-1:0]              col;
    logic [gwps_pkg::DIR_W-1:0] dir;
  } stk_entry_t;

  logic [3:0]                   state_q;
  logic [gwps_pkg::CFG_W-1:0]   row_count_q, col_count_q;
  logic [RW-1:0]                rows_eff;
  logic [CW-1:0]                cols_eff;
  logic [DW-1:0]                len_eff, len_q, depth_q;
  stk_entry_t                   cur_q, nb_q, start_q, nb_d, stk_rdata_q;
  logic                         nb_ok, nb_sub, start_last;
  logic [GW-1:0]                nb_off, clr_q;
  logic                         done_q, found_q;

  // Memories and their ports.
  logic [gwps_pkg::CHAR_W-1:0]  grid_mem [GRID];
  logic [gwps_pkg::CHAR_W-1:0]  word_mem [MAX_WORD];
  logic                         vis_mem  [GRID];
  stk_entry_t                   stk_mem  [MAX_WORD];
  logic [gwps_pkg::CHAR_W-1:0]  grid_rdata_q, word_rdata_q;
  logic                         vis_rdata_q;
  logic [GW-1:0]                grid_raddr, vis_waddr;
  logic                         grid_we, word_we, vis_we, vis_wdata, stk_we;
  logic                         req_ok, match_ok;

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign path_found_o = found_q;
  assign req_ok       = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= gwps_pkg::CFG_W'(1);
      col_count_q <= gwps_pkg::CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gwps_pkg::CFG_ROW_COUNT: row_count_q <= cfg_wdata_i;
        gwps_pkg::CFG_COL_COUNT: col_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Grid sizes and word length clamped to what the storage holds.
  assign rows_eff = (int'(row_count_q) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(row_count_q);
  assign cols_eff = (int'(col_count_q) > MAX_COLS) ? CW'(MAX_COLS) : CW'(col_count_q);
  assign len_eff  = (int'(word_length_i) > MAX_WORD) ? DW'(MAX_WORD) : DW'(word_length_i);

  // Neighbor of the path top in its current direction, through one shared adder.
  always_comb begin
    nb_d      = cur_q;
    nb_d.dir  = gwps_pkg::DIR_LEFT;
    nb_ok     = 1'b0;
    nb_sub    = (cur_q.dir == gwps_pkg::DIR_LEFT) || (cur_q.dir == gwps_pkg::DIR_UP);
    nb_off    = ((cur_q.dir == gwps_pkg::DIR_LEFT) || (cur_q.dir == gwps_pkg::DIR_RIGHT))
                ? GW'(1) : GW'(cols_eff);
    nb_d.pos  = cur_q.pos + (nb_sub ? (~nb_off + GW'(1)) : nb_off);
    case (cur_q.dir)
      gwps_pkg::DIR_LEFT: begin
        nb_ok     = (cur_q.col != '0);
        nb_d.col  = cur_q.col - CW'(1);
      end
      gwps_pkg::DIR_UP: begin
        nb_ok     = (cur_q.row != '0);
        nb_d.row  = cur_q.row - RW'(1);
      end
      gwps_pkg::DIR_RIGHT: begin
        nb_ok     = ((CW+1)'(cur_q.col) + (CW+1)'(1)) < (CW+1)'(cols_eff);
        nb_d.col  = cur_q.col + CW'(1);
      end
      gwps_pkg::DIR_DOWN: begin
        nb_ok     = ((RW+1)'(cur_q.row) + (RW+1)'(1)) < (RW+1)'(rows_eff);
        nb_d.row  = cur_q.row + RW'(1);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  // The current start cell is the last one of the grid in use.
  assign start_last = (((CW+1)'(start_q.col) + (CW+1)'(1)) == (CW+1)'(cols_eff)) &&
                      (((RW+1)'(start_q.row) + (RW+1)'(1)) == (RW+1)'(rows_eff));

  // Memory port control.
  assign match_ok   = !vis_rdata_q && (grid_rdata_q == word_rdata_q);
  assign grid_raddr = (state_q == S_LOOP) ? nb_d.pos : start_q.pos;
  assign grid_we    = req_ok && (mode_i == gwps_pkg::MODE_LOAD_GRID) &&
                      (int'(slot_index_i) < GRID);
  assign word_we    = req_ok && (mode_i == gwps_pkg::MODE_LOAD_WORD) &&
                      (int'(slot_index_i) < MAX_WORD);
  assign stk_we     = (state_q == S_CHK) && match_ok;

  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = cur_q.pos;
    vis_wdata = 1'b0;
    case (state_q)
      S_INIT: begin
        vis_we    = 1'b1;
        vis_waddr = clr_q;
      end
      S_CMP: begin
        vis_we    = (grid_rdata_q == word_rdata_q);
        vis_waddr = start_q.pos;
        vis_wdata = 1'b1;
      end
      S_LOOP: vis_we = (depth_q != len_q) && (cur_q.dir == gwps_pkg::DIR_DONE);
      S_CHK: begin
        vis_we    = match_ok;
        vis_waddr = nb_q.pos;
        vis_wdata = 1'b1;
      end
      S_CLEAN: vis_we = 1'b1;
      default: vis_we = 1'b0;
    endcase
  end

  // Grid memory.
  always_ff @(posedge clk_i) begin
    if (grid_we) grid_mem[GW'(slot_index_i)] <= char_value_i;
    grid_rdata_q <= grid_mem[grid_raddr];
  end

  // Word memory, read at the position of the next character to match.
  always_ff @(posedge clk_i) begin
    if (word_we) word_mem[WW'(slot_index_i)] <= char_value_i;
    word_rdata_q <= word_mem[WW'(depth_q)];
  end

  // Visited map.
  always_ff @(posedge clk_i) begin
    if (vis_we) vis_mem[vis_waddr] <= vis_wdata;
    vis_rdata_q <= vis_mem[nb_d.pos];
  end

  // Path stack below the top entry, read one below the top for a step back.
  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[WW'(depth_q - DW'(1))] <= cur_q;
    stk_rdata_q <= stk_mem[WW'(depth_q - DW'(2))];
  end

  // Search sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      clr_q   <= '0;
      len_q   <= '0;
      depth_q <= '0;
      cur_q   <= '0;
      nb_q    <= '0;
      start_q <= '0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_INIT: begin
          clr_q <= clr_q + GW'(1);
          if (clr_q == GW'(GRID - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (req_ok && (mode_i == gwps_pkg::MODE_SEARCH)) begin
            len_q   <= len_eff;
            depth_q <= '0;
            start_q <= '0;
            if ((rows_eff == '0) || (cols_eff == '0)) begin
              done_q  <= 1'b1;
              found_q <= 1'b0;
            end else if (len_eff == '0) begin
              done_q  <= 1'b1;
              found_q <= 1'b1;
            end else begin
              state_q <= S_RD;
            end
          end
        end
        S_RD: state_q <= S_CMP;
        S_CMP: begin
          if (grid_rdata_q == word_rdata_q) begin
            // The start position always carries the left direction.
            cur_q     <= start_q;
            depth_q   <= DW'(1);
            state_q   <= S_LOOP;
          end else begin
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (start_last) begin
            done_q  <= 1'b1;
            found_q <= 1'b0;
            depth_q <= '0;
            state_q <= S_IDLE;
          end else begin
            if (((CW+1)'(start_q.col) + (CW+1)'(1)) == (CW+1)'(cols_eff)) begin
              start_q <= '{pos: start_q.pos + GW'(1), row: start_q.row + RW'(1),
                           col: '0, dir: gwps_pkg::DIR_LEFT};
            end else begin
              start_q <= '{pos: start_q.pos + GW'(1), row: start_q.row,
                           col: start_q.col + CW'(1), dir: gwps_pkg::DIR_LEFT};
            end
            state_q <= S_RD;
          end
        end
        S_LOOP: begin
          if (depth_q == len_q) begin
            done_q  <= 1'b1;
            found_q <= 1'b1;
            state_q <= S_CLEAN;
          end else if (cur_q.dir == gwps_pkg::DIR_DONE) begin
            // Step back: drop the top and reload the entry below it.
            depth_q <= depth_q - DW'(1);
            state_q <= (depth_q == DW'(1)) ? S_NEXT : S_POPW;
          end else begin
            cur_q.dir <= cur_q.dir + gwps_pkg::DIR_W'(1);
            nb_q      <= nb_d;
            if (nb_ok) state_q <= S_CHK;
          end
        end
        S_CHK: begin
          // Extend the path when the neighbor is free and spells the next character.
          if (match_ok) begin
            cur_q   <= nb_q;
            depth_q <= depth_q + DW'(1);
          end
          state_q <= S_LOOP;
        end
        S_POPW: begin
          cur_q   <= stk_rdata_q;
          state_q <= S_LOOP;
        end
        S_CLEAN: begin
          // Unmark the found path so the next search starts from a clear map.
          depth_q <= depth_q - DW'(1);
          state_q <= (depth_q == DW'(1)) ? S_IDLE : S_CLEANW;
        end
        S_CLEANW: begin
          cur_q   <= stk_rdata_q;
          state_q <= S_CLEAN;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // An idle unit holds an empty path.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (depth_q == '0)) else $error("path not empty while idle");

  // The path never grows beyond the word length.
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= len_q) else $error("path deeper than the word");

  // The top direction never runs past the last neighbor.
  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q.dir <= gwps_pkg::DIR_DONE) else $error("direction out of range");
`endif

endmodule

// ===== tb/grid_word_path_search_unit_checker.sv =====
// Checker for the grid word path search unit: mirrors the stores and predicts every search.
module grid_word_path_search_unit_checker #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16,
  parameter int MAX_WORD = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        busy,
  input  logic [gwps_pkg::MODE_W-1:0] mode_i,
  input  logic [gwps_pkg::SLOT_W-1:0] slot_index_i,
  input  logic [gwps_pkg::CHAR_W-1:0] char_value_i,
  input  logic [gwps_pkg::LEN_W-1:0]  word_length_i,
  input  logic                        done_i,
  input  logic                        path_found_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [gwps_pkg::CFG_W-1:0]  cfg_wdata_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_CELLS   = MAX_ROWS * MAX_COLS;
  localparam int REPORT_LIMIT = 10;

  logic [gwps_pkg::CHAR_W-1:0] grid_mem [GRID_CELLS];
  logic [gwps_pkg::CHAR_W-1:0] word_mem [MAX_WORD];
  logic [gwps_pkg::CFG_W-1:0]  row_cfg;
  logic [gwps_pkg::CFG_W-1:0]  col_cfg;
  bit                          found_q [$];
  bit                          exp_found;
  int                          n_errors;

  // Depth-first walk over the grid with an explicit path stack; starts are tried in
  // row-major order and neighbors left, up, right, down.
  function automatic bit trace_word(input logic [gwps_pkg::LEN_W-1:0] len_in);
    int                         rows, cols, len, total, depth, start_cell, here, r, c, nxt;
    int                         cell_stk [MAX_WORD];
    logic [gwps_pkg::DIR_W-1:0] dir_stk  [MAX_WORD];
    bit                         visited  [GRID_CELLS];
    bit                         stepped;
    rows = (row_cfg > MAX_ROWS) ? MAX_ROWS : int'(row_cfg);
    cols = (col_cfg > MAX_COLS) ? MAX_COLS : int'(col_cfg);
    if (rows == 0 || cols == 0) return 1'b0;
    len = (len_in > MAX_WORD) ? MAX_WORD : int'(len_in);
    if (len == 0) return 1'b1;
    total = rows * cols;
    visited = '{default: 1'b0};
    for (start_cell = 0; start_cell < total; start_cell++) begin
      if (grid_mem[start_cell] != word_mem[0]) continue;
      visited[start_cell] = 1'b1;
      cell_stk[0] = start_cell;
      dir_stk[0] = gwps_pkg::DIR_LEFT;
      depth = 1;
      while (depth > 0) begin
        if (depth == len) return 1'b1;
        here = cell_stk[depth-1];
        if (dir_stk[depth-1] >= gwps_pkg::DIR_DONE) begin
          // All neighbors tried: free the cell and step back.
          visited[here] = 1'b0;
          depth--;
        end else begin
          r = here / cols;
          c = here % cols;
          stepped = 1'b1;
          case (dir_stk[depth-1])
            gwps_pkg::DIR_LEFT:  if (c > 0) c--; else stepped = 1'b0;
            gwps_pkg::DIR_UP:    if (r > 0) r--; else stepped = 1'b0;
            gwps_pkg::DIR_RIGHT: if (c + 1 < cols) c++; else stepped = 1'b0;
            default:             if (r + 1 < rows) r++; else stepped = 1'b0;
          endcase
          dir_stk[depth-1] = dir_stk[depth-1] + gwps_pkg::DIR_W'(1);
          nxt = r * cols + c;
          if (stepped && !visited[nxt] && grid_mem[nxt] == word_mem[depth]) begin
            visited[nxt] = 1'b1;
            cell_stk[depth] = nxt;
            dir_stk[depth] = gwps_pkg::DIR_LEFT;
            depth++;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // Watch the three channels; the store mirror and the size registers follow each edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cfg = gwps_pkg::CFG_W'(1);
      col_cfg = gwps_pkg::CFG_W'(1);
      found_q.delete();
      n_errors = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // The user must change size registers only while the unit is idle; nothing enforces it.
      if (cfg_we_i) begin
        if (cfg_idx_i == gwps_pkg::CFG_ROW_COUNT) row_cfg = cfg_wdata_i;
        else col_cfg = cfg_wdata_i;
      end
      // A finished search is matched against the oldest prediction.
      if (done_i) begin
        if (found_q.size() == 0) begin
          n_errors++;
          if (n_errors <= REPORT_LIMIT)
            $display("%0t: path_found=%0b arrived with no search outstanding",
                     $realtime, path_found_i);
        end else begin
          exp_found = found_q.pop_front();
          if (path_found_i !== exp_found) begin
            n_errors++;
            if (n_errors <= REPORT_LIMIT)
              $display("%0t: path_found mismatch, expected %0b, got %0b",
                       $realtime, exp_found, path_found_i);
          end
        end
      end
      // An accepted request either fills a store or starts a search.
      if (start && !busy) begin
        case (mode_i)
          gwps_pkg::MODE_LOAD_GRID:
            if (slot_index_i < GRID_CELLS) grid_mem[slot_index_i] = char_value_i;
          gwps_pkg::MODE_LOAD_WORD:
            if (slot_index_i < MAX_WORD) word_mem[slot_index_i] = char_value_i;
          gwps_pkg::MODE_SEARCH:
            found_q.push_back(trace_word(word_length_i));
          default: ;
        endcase
      end
      fail_count_o <= n_errors;
      pending_o <= found_q.size();
    end
  end

endmodule

// ===== tb/grid_word_path_search_unit_tb.sv =====
// Testbench top for the grid word path search unit: clock, reset, requests and verdict.
module grid_word_path_search_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [gwps_pkg::MODE_W-1:0] mode_t;
  typedef logic [gwps_pkg::SLOT_W-1:0] slot_t;
  typedef logic [gwps_pkg::CHAR_W-1:0] char_t;
  typedef logic [gwps_pkg::LEN_W-1:0]  len_t;
  typedef logic [gwps_pkg::CFG_W-1:0]  cfg_t;

  localparam int MAX_ROWS   = 16;
  localparam int MAX_COLS   = 16;
  localparam int MAX_WORD   = 32;
  localparam int GRID_CELLS = MAX_ROWS * MAX_COLS;
  localparam int ITEM_TARGET   = 1850;
  localparam int SETTLE_CYCLES = 40;
  // A search on the full grid with the alphabets used here, the reset clearing pass and
  // the longest sender gap all stay far below this limit.
  localparam int QUIET_LIMIT = 200000;
  localparam mode_t MODE_UNUSED = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  mode_t             mode_i;
  slot_t             slot_index_i;
  char_t             char_value_i;
  len_t              word_length_i;
  logic              done_o;
  logic              path_found_o;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  cfg_t              cfg_wdata_i;
  int                fail_count;
  int                pending;
  int unsigned       quiet_cycles;

  char_t             grid_copy [GRID_CELLS];
  int                trail_q [$];
  int                alpha [8];
  int                alpha_n;
  int                items_done;
  bit                steady;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  grid_word_path_search_unit #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS),
    .MAX_WORD(MAX_WORD)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .mode_i(mode_i),
    .slot_index_i(slot_index_i),
    .char_value_i(char_value_i),
    .word_length_i(word_length_i),
    .done_o(done_o),
    .path_found_o(path_found_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  grid_word_path_search_unit_checker #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS),
    .MAX_WORD(MAX_WORD)
  ) checker_i (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .mode_i(mode_i),
    .slot_index_i(slot_index_i),
    .char_value_i(char_value_i),
    .word_length_i(word_length_i),
    .done_i(done_o),
    .path_found_i(path_found_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .fail_count_o(fail_count),
    .pending_o(pending)
  );

  // Watchdog: ends the run when neither a request nor a result moves for too long.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("grid_word_path_search_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly short gaps, now and then a long one; steady phases send back to back.
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp_size(input cfg_t v, input int lim);
    return (v > lim) ? lim : int'(v);
  endfunction

  // Present one request and hold it until the unit takes it.
  task automatic send_req(input mode_t mode, input slot_t slot,
                          input char_t ch, input len_t len);
    int gap;
    start <= 1'b1;
    mode_i <= mode;
    slot_index_i <= slot;
    char_value_i <= ch;
    word_length_i <= len;
    do @(posedge clk_i); while (busy);
    if (mode == gwps_pkg::MODE_LOAD_GRID) grid_copy[slot] = ch;
    if (mode != MODE_UNUSED && !(mode == gwps_pkg::MODE_LOAD_WORD && slot >= MAX_WORD))
      items_done++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop start, wait for every search to report and for busy to fall, then settle.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_sizes(input cfg_t rows, input cfg_t cols);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= gwps_pkg::CFG_ROW_COUNT;
    cfg_wdata_i <= rows;
    @(posedge clk_i);
    cfg_idx_i <= gwps_pkg::CFG_COL_COUNT;
    cfg_wdata_i <= cols;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Requests the unit must ignore: the unused mode or a word slot past the store.
  task automatic maybe_noise();
    if ($urandom_range(0, 9) != 0) return;
    if ($urandom_range(0, 1) == 0)
      send_req(MODE_UNUSED, slot_t'($urandom), char_t'($urandom), len_t'($urandom));
    else
      send_req(gwps_pkg::MODE_LOAD_WORD, slot_t'($urandom_range(MAX_WORD, 255)),
               char_t'($urandom), len_t'($urandom));
  endtask

  // Small grids may use few letters; larger ones need more so failed searches stay short.
  task automatic pick_alphabet(input int total);
    int lo, hi, i, base, stride;
    if (total <= 9) begin
      lo = 1;
      hi = 3;
    end else if (total <= 16) begin
      lo = 2;
      hi = 4;
    end else if (total <= 36) begin
      lo = 3;
      hi = 5;
    end else begin
      lo = 4;
      hi = 8;
    end
    alpha_n = $urandom_range(lo, hi);
    base = $urandom_range(0, 255);
    stride = 2 * $urandom_range(0, 127) + 1;
    for (i = 0; i < alpha_n; i++) alpha[i] = (base + i * stride) % 256;
  endtask

  // Random self-avoiding walk through the grid; stops early when it gets boxed in.
  task automatic build_trail(input int er, input int ec, input int want);
    bit used [GRID_CELLS];
    int opts [$];
    int here, r, c;
    used = '{default: 1'b0};
    here = $urandom_range(0, er * ec - 1);
    trail_q = {here};
    used[here] = 1'b1;
    while (trail_q.size() < want) begin
      opts.delete();
      r = here / ec;
      c = here % ec;
      if (c > 0 && !used[here-1]) opts.push_back(here - 1);
      if (r > 0 && !used[here-ec]) opts.push_back(here - ec);
      if (c + 1 < ec && !used[here+1]) opts.push_back(here + 1);
      if (r + 1 < er && !used[here+ec]) opts.push_back(here + ec);
      if (opts.size() == 0) break;
      here = opts[$urandom_range(0, opts.size() - 1)];
      used[here] = 1'b1;
      trail_q.push_back(here);
    end
  endtask

  // One search, mostly on a word traced from the grid, sometimes with a broken letter.
  task automatic run_one_search(input int total, input int er, input int ec);
    int kind, len, n, i, bad;
    if (total > 0 && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3))
        send_req(gwps_pkg::MODE_LOAD_GRID, slot_t'($urandom_range(0, total - 1)),
                 char_t'(alpha[$urandom_range(0, alpha_n - 1)]), len_t'($urandom));
    kind = $urandom_range(0, 9);
    if (kind <= 5 && total > 0) begin
      build_trail(er, ec, $urandom_range(1, (total < MAX_WORD) ? total : MAX_WORD));
      bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, trail_q.size() - 1) : -1;
      for (i = 0; i < trail_q.size(); i++)
        send_req(gwps_pkg::MODE_LOAD_WORD, slot_t'(i),
                 (i == bad) ? char_t'($urandom) : grid_copy[trail_q[i]],
                 len_t'($urandom));
      len = trail_q.size();
    end else if (kind == 6) begin
      len = $urandom_range(0, MAX_WORD);
    end else if (kind == 7 && total > 0) begin
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++)
        send_req(gwps_pkg::MODE_LOAD_WORD, slot_t'(i),
                 char_t'(alpha[$urandom_range(0, alpha_n - 1)]), len_t'($urandom));
      len = n;
    end else if (kind == 8) begin
      len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_WORD + 1, 63);
    end else begin
      len = $urandom_range(1, 2);
    end
    maybe_noise();
    send_req(gwps_pkg::MODE_SEARCH, slot_t'($urandom), char_t'($urandom), len_t'(len));
  endtask

  initial begin
    int   i, phase, sel, er, ec, total;
    cfg_t row_val, col_val;
    rst_ni <= 1'b0;
    start <= 1'b0;
    mode_i <= gwps_pkg::MODE_LOAD_GRID;
    slot_index_i <= '0;
    char_value_i <= '0;
    word_length_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= gwps_pkg::CFG_ROW_COUNT;
    cfg_wdata_i <= '0;
    steady = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    // Directed: a 2x2 grid with zero and all-ones bytes, empty and full-tour words.
    write_sizes(5'd2, 5'd2);
    send_req(gwps_pkg::MODE_LOAD_GRID, 8'd0, 8'h00, 6'd0);
    send_req(gwps_pkg::MODE_LOAD_GRID, 8'd1, 8'hFF, 6'd0);
    send_req(gwps_pkg::MODE_LOAD_GRID, 8'd2, 8'h5A, 6'd0);
    send_req(gwps_pkg::MODE_LOAD_GRID, 8'd3, 8'h00, 6'd0);
    send_req(gwps_pkg::MODE_LOAD_WORD, 8'd0, 8'h00, 6'd0);
    send_req(gwps_pkg::MODE_LOAD_WORD, 8'd1, 8'hFF, 6'd0);
    send_req(gwps_pkg::MODE_LOAD_WORD, 8'd2, 8'h00, 6'd0);
    send_req(gwps_pkg::MODE_LOAD_WORD, 8'd3, 8'h5A, 6'd0);
    send_req(gwps_pkg::MODE_SEARCH, 8'hFF, 8'hFF, 6'd0);
    send_req(gwps_pkg::MODE_SEARCH, 8'd0, 8'd0, 6'd4);
    send_req(gwps_pkg::MODE_SEARCH, 8'd0, 8'd0, 6'd3);
    // Ignored requests must leave the stores alone.
    send_req(MODE_UNUSED, 8'hFF, 8'hFF, 6'h3F);
    send_req(gwps_pkg::MODE_LOAD_WORD, 8'hFF, 8'h11, 6'd0);
    send_req(gwps_pkg::MODE_LOAD_WORD, 8'd32, 8'h11, 6'd0);
    send_req(gwps_pkg::MODE_SEARCH, 8'd0, 8'd0, 6'd4);
    // A zero dimension answers no, even for the empty word.
    wait_idle();
    write_sizes(5'd0, 5'd16);
    send_req(gwps_pkg::MODE_SEARCH, 8'd0, 8'd0, 6'd2);
    send_req(gwps_pkg::MODE_SEARCH, 8'd0, 8'd0, 6'd0);
    wait_idle();
    write_sizes(5'd31, 5'd0);
    send_req(gwps_pkg::MODE_SEARCH, 8'd0, 8'd0, 6'd1);
    // Single cell grid.
    wait_idle();
    write_sizes(5'd1, 5'd1);
    send_req(gwps_pkg::MODE_SEARCH, 8'd0, 8'd0, 6'd1);
    send_req(gwps_pkg::MODE_SEARCH, 8'd0, 8'd0, 6'd2);

    // Random phases: fill the whole word store once, then a new grid shape per phase.
    items_done = 0;
    for (i = 0; i < MAX_WORD; i++)
      send_req(gwps_pkg::MODE_LOAD_WORD, slot_t'(i), char_t'($urandom), len_t'($urandom));
    phase = 0;
    while (items_done < ITEM_TARGET) begin
      wait_idle();
      sel = $urandom_range(0, 39);
      if (phase == 0) begin
        row_val = cfg_t'(16);
        col_val = cfg_t'($urandom_range(16, 31));
      end else if (sel == 0) begin
        row_val = cfg_t'($urandom_range(17, 31));
        col_val = cfg_t'($urandom_range(1, 31));
      end else if (sel <= 2) begin
        row_val = cfg_t'((sel == 1) ? 0 : $urandom_range(0, 31));
        col_val = cfg_t'((sel == 1) ? $urandom_range(0, 31) : 0);
      end else if (sel <= 6) begin
        row_val = cfg_t'(1);
        col_val = cfg_t'($urandom_range(1, 16));
      end else if (sel <= 9) begin
        row_val = cfg_t'($urandom_range(1, 16));
        col_val = cfg_t'(1);
      end else begin
        row_val = cfg_t'($urandom_range(1, 6));
        col_val = cfg_t'($urandom_range(1, 6));
      end
      write_sizes(row_val, col_val);
      er = clamp_size(row_val, MAX_ROWS);
      ec = clamp_size(col_val, MAX_COLS);
      total = er * ec;
      steady = ($urandom_range(0, 3) == 0);
      pick_alphabet(total);
      // Every cell in use is written before the first search of the phase.
      for (i = 0; i < total; i++) begin
        maybe_noise();
        send_req(gwps_pkg::MODE_LOAD_GRID, slot_t'(i),
                 char_t'(alpha[$urandom_range(0, alpha_n - 1)]), len_t'($urandom));
      end
      repeat ($urandom_range(3, 8)) run_one_search(total, er, ec);
      phase++;
    end
    steady = 1'b0;
    wait_idle();

    if (fail_count == 0 && pending == 0) begin
      $display("grid_word_path_search_unit test passed");
    end else begin
      $display("grid_word_path_search_unit test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gwps_pkg.sv
rtl/grid_word_path_search_unit.sv
tb/grid_word_path_search_unit_checker.sv
tb/grid_word_path_search_unit_tb.sv
